// ===== rtl/core/snau_pkg.sv =====
// Shared types, constants and fixed-point helpers for the spiking neuron array update unit.
// Used by the top level, snau_shaper, snau_fifo and snau_back; depends on nothing else.
package snau_pkg;

	localparam int unsigned IDX_W       = 10;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned QPTR_W      = 3;
	localparam int unsigned QCNT_W      = 4;

	localparam logic signed [DATA_W-1:0] ONE_Q20  = 32'sd1048576;
	localparam logic signed [DATA_W-1:0] POS_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] NEG_MIN  = 32'sh8000_0000;
	localparam logic signed [63:0]       HALF_LSB = 64'sd524288;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIGNAL_CEILING   = 3'd0,
		CFG_SHAPE_COEFF      = 3'd1,
		CFG_INV_CEILING_SQ   = 3'd2,
		CFG_DECAY_RATE       = 3'd3,
		CFG_RECOVERY_LEVEL   = 3'd4,
		CFG_INITIAL_LEVEL    = 3'd5,
		CFG_SPIKING_THRESH   = 3'd6,
		CFG_NEGATIVE_GAIN    = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [30:0]        signal_ceiling;
		logic signed [31:0] shape_coefficient;
		logic [20:0]        inverse_ceiling_squared;
		logic signed [31:0] decay_rate;
		logic signed [21:0] recovery_level;
		logic signed [21:0] initial_level;
		logic signed [21:0] spiking_threshold;
		logic [20:0]        negative_gain;
	} cfg_regs_t;

	// word handed from the shaping front to the excitation back
	typedef struct packed {
		logic               action;
		logic [IDX_W-1:0]   idx;
		logic signed [31:0] shaped;
	} queue_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   neuron_echo;
		logic signed [31:0] shaped_input;
		logic signed [31:0] new_excitation;
		logic               spiked;
	} result_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(POS_MAX))
			r = POS_MAX;
		else if (v < 64'(NEG_MIN))
			r = NEG_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	// Q12.20 product, round half up, saturated
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + HALF_LSB;
		return sat32(p >>> 20);
	endfunction

endpackage

// ===== rtl/core/spiking_neuron_array_update_unit.sv =====
// Top level of the spiking neuron array update unit: ports, configuration, credit control.
// Depends on snau_pkg, snau_shaper, snau_fifo and snau_back.
//
// Takes one item per clock while s_axis_tready is high and gives one result per item, in
// order. After reset the excitation store is cleared one entry a cycle, with s_axis_tready
// low. An item passes through the shaping pipeline, the queue, the store read, decay
// multiply and update stages, and the result register. An item for a neuron that is still
// in the store read or update stages ahead of it is held in the queue, because of the
// read-modify-write loop through the store memory. Configuration is taken at once
// (cfg_ready is always high) and must change only while the unit is idle.
module spiking_neuron_array_update_unit #(
	parameter int NEURON_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // neuron_number[9:0], raw_input[41:10], zero[47:42]
	input  logic        s_axis_tuser,   // action[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // neuron_echo[9:0], shaped_input[41:10],
	                                    // new_excitation[73:42], zero[79:74]
	output logic        m_axis_tuser,   // spiked[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import snau_pkg::*;

	cfg_regs_t   cfg_q;
	logic [QCNT_W-1:0] credit_q;
	logic        accept, front_valid, q_not_empty, q_pop, clearing, res_valid;
	queue_item_t front_item, q_head;
	result_t     res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !clearing && (credit_q < QCNT_W'(QUEUE_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signal_ceiling          <= 31'd1048576;
			cfg_q.shape_coefficient       <= '0;
			cfg_q.inverse_ceiling_squared <= 21'd1048576;
			cfg_q.decay_rate              <= -32'sd31457;
			cfg_q.recovery_level          <= '0;
			cfg_q.initial_level           <= '0;
			cfg_q.spiking_threshold       <= 22'sd943718;
			cfg_q.negative_gain           <= 21'd104858;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SIGNAL_CEILING: cfg_q.signal_ceiling          <= cfg_data[30:0];
				CFG_SHAPE_COEFF:    cfg_q.shape_coefficient       <= cfg_data;
				CFG_INV_CEILING_SQ: cfg_q.inverse_ceiling_squared <= cfg_data[20:0];
				CFG_DECAY_RATE:     cfg_q.decay_rate              <= cfg_data;
				CFG_RECOVERY_LEVEL: cfg_q.recovery_level          <= cfg_data[21:0];
				CFG_INITIAL_LEVEL:  cfg_q.initial_level           <= cfg_data[21:0];
				CFG_SPIKING_THRESH: cfg_q.spiking_threshold       <= cfg_data[21:0];
				CFG_NEGATIVE_GAIN:  cfg_q.negative_gain           <= cfg_data[20:0];
			endcase
		end
	end

	// count words in the front and queue so the queue never overflows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			credit_q <= '0;
		else
			credit_q <= credit_q + QCNT_W'(accept) - QCNT_W'(q_pop);
	end

	snau_shaper u_shaper (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_action (s_axis_tuser),
		.in_idx    (s_axis_tdata[9:0]),
		.in_raw    ($signed(s_axis_tdata[41:10])),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_item  (front_item)
	);

	snau_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_item (front_item),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	snau_back #(
		.NEURON_COUNT (NEURON_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_item    (q_head),
		.cfg       (cfg_q),
		.out_ready (m_axis_tready),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res       (res)
	);

	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {6'b0, res.new_excitation, res.shaped_input, res.neuron_echo};
	assign m_axis_tuser  = res.spiked;

endmodule

// ===== rtl/core/snau_shaper.sv =====
// Front part: cubic transfer shaping of the raw input, six register stages.
// Depends on snau_pkg.
module snau_shaper (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_action,
	input  logic [snau_pkg::IDX_W-1:0] in_idx,
	input  logic signed [31:0]      in_raw,
	input  snau_pkg::cfg_regs_t     cfg,
	output logic                    out_valid,
	output snau_pkg::queue_item_t   out_item
);
	import snau_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic act_s1, act_s2, act_s3, act_s4, act_s5, act_s6;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [31:0] x_s1, x_s2, x_s3, x_s4;
	logic signed [31:0] dx_s1, xm2_s1, sq_s2, t2_s2, t1_s3, t2_s3, diff_s4, y_s5, shaped_s6;

	logic signed [31:0] ceil_d, mag_x, gain_neg;
	logic signed [33:0] x_minus_2d;

	// clamp the ceiling to at least one and take the saturated magnitude
	always_comb begin
		ceil_d = (cfg.signal_ceiling < 31'd1048576) ? ONE_Q20 : $signed({1'b0, cfg.signal_ceiling});
		if (in_raw == NEG_MIN)
			mag_x = POS_MAX;
		else if (in_raw[31])
			mag_x = -in_raw;
		else
			mag_x = in_raw;
		x_minus_2d = $signed({2'b00, mag_x}) - $signed({1'b0, ceil_d, 1'b0});
		gain_neg = -$signed({11'b0, cfg.negative_gain});
	end

	// advance valid bits every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {in_valid, v_s1, v_s2, v_s3, v_s4, v_s5};
		end
	end

	// datapath: differences, squares, cubic terms, gain
	always_ff @(posedge clk) begin
		act_s1 <= in_action;
		idx_s1 <= in_idx;
		neg_s1 <= in_raw[31];
		x_s1   <= mag_x;
		dx_s1  <= mag_x - ceil_d;
		xm2_s1 <= sat32(64'(x_minus_2d));

		act_s2 <= act_s1;
		idx_s2 <= idx_s1;
		neg_s2 <= neg_s1;
		x_s2   <= x_s1;
		sq_s2  <= mulq(dx_s1, dx_s1);
		t2_s2  <= mulq(xm2_s1, $signed({11'b0, cfg.inverse_ceiling_squared}));

		act_s3 <= act_s2;
		idx_s3 <= idx_s2;
		neg_s3 <= neg_s2;
		x_s3   <= x_s2;
		t1_s3  <= mulq(cfg.shape_coefficient, sq_s2);
		t2_s3  <= t2_s2;

		act_s4  <= act_s3;
		idx_s4  <= idx_s3;
		neg_s4  <= neg_s3;
		x_s4    <= x_s3;
		diff_s4 <= sat32(64'(t1_s3) - 64'(t2_s3));

		act_s5 <= act_s4;
		idx_s5 <= idx_s4;
		neg_s5 <= neg_s4;
		y_s5   <= mulq(x_s4, diff_s4);

		act_s6 <= act_s5;
		idx_s6 <= idx_s5;
		if (act_s5)
			shaped_s6 <= '0;
		else if (neg_s5)
			shaped_s6 <= mulq(gain_neg, y_s5);
		else
			shaped_s6 <= y_s5;
	end

	assign out_valid       = v_s6;
	assign out_item.action = act_s6;
	assign out_item.idx    = idx_s6;
	assign out_item.shaped = shaped_s6;

endmodule

// ===== rtl/core/snau_fifo.sv =====
// Short queue between the shaping front and the excitation back.
// Depends on snau_pkg; overflow is prevented by the credit count at the top level.
module snau_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  snau_pkg::queue_item_t push_item,
	input  logic                  pop,
	output logic                  not_empty,
	output snau_pkg::queue_item_t head
);
	import snau_pkg::*;

	queue_item_t       entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// store the incoming word
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

endmodule

// ===== rtl/core/snau_back.sv =====
// Back part: excitation store, decay, spike decision and result register.
// Depends on snau_pkg; holds the store memory and its clearing pass.
module snau_back #(
	parameter int NEURON_COUNT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  snau_pkg::queue_item_t q_item,
	input  snau_pkg::cfg_regs_t   cfg,
	input  logic                  out_ready,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  res_valid,
	output snau_pkg::result_t     res
);
	import snau_pkg::*;

	localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
	localparam logic [16:0] NCOUNT = 17'(NEURON_COUNT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NEURON_COUNT - 1);

	logic signed [31:0] store_mem [NEURON_COUNT];

	logic adv, hazard, in_ok;
	logic v_s1, v_s2, v_s3;
	logic act_s1, act_s2, act_s3;
	logic ok_s1, ok_s2, ok_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [31:0] shaped_s1, shaped_s2, shaped_s3;
	logic signed [31:0] rd_s2, old_s3, prod_s3;
	logic spk_s3;
	logic clr_q;
	logic [AW-1:0] clr_addr_q;
	logic res_valid_q;
	result_t res_q;

	logic signed [31:0] old_val, sum_decay, sum_in, nxt_exc;

	assign adv    = !res_valid_q || out_ready;
	assign in_ok  = (17'(q_item.idx) < NCOUNT);
	// hold a word whose neuron is still being read or updated ahead of it
	assign hazard = in_ok && ((v_s1 && ok_s1 && idx_s1 == q_item.idx) ||
		(v_s2 && ok_s2 && idx_s2 == q_item.idx));
	assign q_pop  = q_valid && adv && !hazard && !clr_q;

	// old excitation, spike test and update
	always_comb begin
		old_val   = ok_s2 ? rd_s2 : '0;
		sum_decay = sat32(64'(old_s3) + 64'(prod_s3));
		sum_in    = sat32(64'(sum_decay) + 64'(shaped_s3));
		if (act_s3)
			nxt_exc = 32'(cfg.initial_level);
		else if (spk_s3)
			nxt_exc = 32'(cfg.recovery_level);
		else
			nxt_exc = sum_in;
	end

	// valid bits, clearing pass, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3} <= '0;
			res_valid_q <= 1'b0;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			if (adv) begin
				{v_s1, v_s2, v_s3} <= {q_pop, v_s1, v_s2};
				res_valid_q <= v_s3;
			end
			if (clr_q) begin
				if (clr_addr_q == LAST_ADDR)
					clr_q <= 1'b0;
				else
					clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// payload stages and result register
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1    <= q_item.action;
			idx_s1    <= q_item.idx;
			ok_s1     <= in_ok;
			shaped_s1 <= q_item.shaped;

			act_s2    <= act_s1;
			idx_s2    <= idx_s1;
			ok_s2     <= ok_s1;
			shaped_s2 <= shaped_s1;

			act_s3    <= act_s2;
			idx_s3    <= idx_s2;
			ok_s3     <= ok_s2;
			shaped_s3 <= shaped_s2;
			old_s3    <= old_val;
			prod_s3   <= mulq(old_val, cfg.decay_rate);
			spk_s3    <= (old_val >= 32'(cfg.spiking_threshold));

			res_q.neuron_echo    <= idx_s3;
			res_q.shaped_input   <= shaped_s3;
			res_q.new_excitation <= nxt_exc;
			res_q.spiked         <= !act_s3 && spk_s3;
		end
	end

	// store: clear after reset, read on advance, write back the update
	always_ff @(posedge clk) begin
		if (clr_q)
			store_mem[clr_addr_q] <= '0;
		else if (adv && v_s3 && ok_s3)
			store_mem[AW'(idx_s3)] <= nxt_exc;
		if (adv)
			rd_s2 <= store_mem[AW'(idx_s1)];
	end

	assign clearing  = clr_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/snau_checker.sv =====
// Port-level checks for the spiking neuron array update unit, bound to the top level.
// Depends on the top level's port list only.
module snau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic [4:0] outstanding_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else
			outstanding_q <= outstanding_q + 5'(in_acc) - 5'(out_acc);
	end

	// a result is never shown without an input word behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> outstanding_q != 5'd0)
		else $error("result shown with no word outstanding");

	// credit keeps the words in flight bounded
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 5'd12)
		else $error("too many words in flight");

	// a spiking neuron takes the recovery level, a 22-bit value
	a_spike_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_axis_tuser |->
			(m_axis_tdata[73:63] == 11'h000) || (m_axis_tdata[73:63] == 11'h7FF))
		else $error("spike result outside the recovery range");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

endmodule

bind spiking_neuron_array_update_unit snau_checker u_snau_checker (.*);
